// File: src/rlud_pkg.sv
// ----------------------------------------------------------------------------
// rlud_pkg: shared types and constants for the run-length unit decoder
// Holds the decoder state, the result record, status codes and register
// indexes.
// ----------------------------------------------------------------------------
package rlud_pkg;

  localparam int unsigned MaxOutputBytes = 268435456;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 29;
  localparam int unsigned StartW  = 28;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned RunW    = 8;
  localparam int unsigned StatusW = 3;

  // Configuration register indexes
  localparam logic CfgStrideMode = 1'b0;
  localparam logic CfgUnitCount  = 1'b1;

  // Decoder phase codes
  localparam logic PhMarker = 1'b0;
  localparam logic PhUnit   = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StRunning     = 3'd0,
    StDoneOk      = 3'd1,
    StCountLarge  = 3'd2,
    StRunOverflow = 3'd3,
    StTruncated   = 3'd4,
    StMismatch    = 3'd5
  } status_e;

  typedef struct packed {
    logic              phase;
    logic [RunW-1:0]   units_left;
    logic              run_is_repeat;
    logic [1:0]        byte_in_unit;
    logic [23:0]       unit_bytes;
    logic [CountW-1:0] units_done;
    logic              discarding;
  } rlud_state_t;

  typedef struct packed {
    logic              unit_valid;
    logic [ValueW-1:0] unit_value;
    logic [RunW-1:0]   run_units;
    logic [StartW-1:0] start_unit;
    status_e           status;
  } rlud_result_t;

endpackage

// File: src/rlud_step.sv
// ----------------------------------------------------------------------------
// rlud_step: next-state and result logic for one packed byte
// Pure combinational step of the decoder: marker parsing, unit assembly,
// run accounting and error detection.
// ----------------------------------------------------------------------------
module rlud_step (
  input  rlud_pkg::rlud_state_t           state_i,
  input  logic [rlud_pkg::ByteW-1:0]      byte_i,
  input  logic                            last_i,
  input  logic                            stride_mode_i,
  input  logic [rlud_pkg::CountW-1:0]     unit_count_i,
  output rlud_pkg::rlud_state_t           state_o,
  output logic                            res_valid_o,
  output rlud_pkg::rlud_result_t          res_o
);

  localparam logic [rlud_pkg::CountW+1:0] MaxBytes =
    (rlud_pkg::CountW+2)'(rlud_pkg::MaxOutputBytes);

  logic [rlud_pkg::CountW+1:0] scaled_count;
  logic                        too_large;
  logic [8:0]                  run_len;
  logic [rlud_pkg::CountW-1:0] remaining;
  logic [rlud_pkg::ValueW-1:0] value;
  logic [rlud_pkg::RunW-1:0]   run;
  logic [rlud_pkg::CountW-1:0] done_new;
  logic [rlud_pkg::RunW-1:0]   left_new;
  logic                        fail_en;
  rlud_pkg::status_e           fail_code;

  assign scaled_count = stride_mode_i ? {unit_count_i, 2'b00} : {2'b00, unit_count_i};
  assign too_large    = scaled_count > MaxBytes;
  assign run_len      = byte_i[7] ? ({2'b00, byte_i[6:0]} + 9'd3) : ({1'b0, byte_i} + 9'd1);
  assign remaining    = unit_count_i - state_i.units_done;
  assign value        = {8'h00, state_i.unit_bytes} |
                        ({24'h000000, byte_i} << {state_i.byte_in_unit, 3'b000});
  assign run          = state_i.run_is_repeat ? state_i.units_left : 8'd1;
  assign done_new     = state_i.units_done + {{(rlud_pkg::CountW-rlud_pkg::RunW){1'b0}}, run};
  assign left_new     = state_i.run_is_repeat ? 8'd0 : (state_i.units_left - 8'd1);

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = rlud_pkg::StRunning;
    fail_en     = 1'b0;
    fail_code   = rlud_pkg::StRunning;

    if (state_i.discarding) begin
      if (last_i) begin
        state_o = '0;
      end
    end else if (too_large) begin
      fail_en   = 1'b1;
      fail_code = rlud_pkg::StCountLarge;
    end else if (state_i.phase == rlud_pkg::PhMarker) begin
      if (state_i.units_done >= unit_count_i) begin
        fail_en   = 1'b1;
        fail_code = rlud_pkg::StMismatch;
      end else if ({20'd0, run_len} > remaining) begin
        fail_en   = 1'b1;
        fail_code = rlud_pkg::StRunOverflow;
      end else if (last_i) begin
        fail_en   = 1'b1;
        fail_code = rlud_pkg::StTruncated;
      end else begin
        // a literal run of 256 wraps to zero; the count-down still ends right
        state_o.units_left    = run_len[7:0];
        state_o.run_is_repeat = byte_i[7];
        state_o.byte_in_unit  = 2'd0;
        state_o.unit_bytes    = '0;
        state_o.phase         = rlud_pkg::PhUnit;
      end
    end else if (stride_mode_i && (state_i.byte_in_unit != 2'd3)) begin
      case (state_i.byte_in_unit)
        2'd0:    state_o.unit_bytes[7:0]   = state_i.unit_bytes[7:0]   | byte_i;
        2'd1:    state_o.unit_bytes[15:8]  = state_i.unit_bytes[15:8]  | byte_i;
        2'd2:    state_o.unit_bytes[23:16] = state_i.unit_bytes[23:16] | byte_i;
        default: state_o.unit_bytes        = state_i.unit_bytes;
      endcase
      state_o.byte_in_unit = state_i.byte_in_unit + 2'd1;
      if (last_i) begin
        fail_en   = 1'b1;
        fail_code = rlud_pkg::StTruncated;
      end
    end else begin
      res_valid_o      = 1'b1;
      res_o.unit_valid = 1'b1;
      res_o.unit_value = value;
      res_o.run_units  = run;
      res_o.start_unit = state_i.units_done[rlud_pkg::StartW-1:0];

      state_o.units_done   = done_new;
      state_o.units_left   = left_new;
      state_o.byte_in_unit = 2'd0;
      state_o.unit_bytes   = '0;
      if (left_new == 8'd0) begin
        state_o.phase = rlud_pkg::PhMarker;
      end

      if (last_i) begin
        if (left_new != 8'd0) begin
          res_o.status = rlud_pkg::StTruncated;
        end else if (done_new == unit_count_i) begin
          res_o.status = rlud_pkg::StDoneOk;
        end else begin
          res_o.status = rlud_pkg::StMismatch;
        end
        state_o = '0;
      end
    end

    // error: report without a unit, then drop the rest of the stream
    if (fail_en) begin
      state_o            = '0;
      state_o.discarding = ~last_i;
      res_valid_o        = 1'b1;
      res_o              = '0;
      res_o.status       = fail_code;
    end
  end

endmodule

// File: src/run_length_unit_decoder.sv
// ----------------------------------------------------------------------------
// run_length_unit_decoder: packed byte stream to run-length unit records
// Decodes repeat and literal runs of one- or four-byte units and reports
// each completed unit with its copy count, start index and stream status.
// ----------------------------------------------------------------------------
// Path: input request to result on the master side goes through the input
//   register, then the result register; the per-byte step is a single pass.
// Throughput: one packed byte per cycle unless the record side stalls.
// Reset: asynchronous, active low; clears registers to stride 0, count 0
//   and the decoder to awaiting a marker with no units done.
module run_length_unit_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [28:0] cfg_data_i,
  // packed byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] packed_byte
  input  logic        s_axis_tlast_i,   // last_byte
  // decoded unit records
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] unit_value, [39:32] run_units,
                                        // [67:40] start_unit, [71:68] zero
  output logic [3:0]  m_axis_tuser_o    // [0] unit_valid, [3:1] status
);

  logic                            stride_mode_q;
  logic [rlud_pkg::CountW-1:0]     unit_count_q;

  logic                            in_vld_q, in_vld_d;
  logic [rlud_pkg::ByteW-1:0]      in_byte_q;
  logic                            in_last_q;

  rlud_pkg::rlud_state_t           state_q, state_d;
  logic                            res_valid;
  rlud_pkg::rlud_result_t          res;

  logic                            out_vld_q, out_vld_d;
  rlud_pkg::rlud_result_t          out_q;

  logic                            proc_go;
  logic                            in_take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_mode_q <= 1'b0;
      unit_count_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rlud_pkg::CfgStrideMode: stride_mode_q <= cfg_data_i[0];
        rlud_pkg::CfgUnitCount:  unit_count_q  <= cfg_data_i;
        default:                 stride_mode_q <= stride_mode_q;
      endcase
    end
  end

  // step fires when a byte is held and the result slot is free or draining
  assign proc_go         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || proc_go;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_vld_d        = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  rlud_step u_step (
    .state_i       (state_q),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .stride_mode_i (stride_mode_q),
    .unit_count_i  (unit_count_q),
    .state_o       (state_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (proc_go) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (proc_go && res_valid) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'h0, out_q.start_unit, out_q.run_units, out_q.unit_value};
  assign m_axis_tuser_o  = {3'(out_q.status), out_q.unit_valid};

  // a record with no unit exists only to carry a nonzero status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.unit_valid) |-> (out_q.status != rlud_pkg::StRunning))
    else $error("unit-less record with running status");

  // unit-less records carry zeroed payload fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.unit_valid) |->
      (out_q.unit_value == '0 && out_q.run_units == '0 && out_q.start_unit == '0))
    else $error("unit-less record with nonzero payload");

  // every emitted unit has a copy count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.unit_valid) |-> (out_q.run_units != '0))
    else $error("unit emitted with zero run length");

  // bytes dropped after an error never produce a record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_go && state_q.discarding) |-> !res_valid)
    else $error("record produced while discarding");

endmodule

// File: test/rlud_record_checker.sv
// ----------------------------------------------------------------------------
// rlud_record_checker: record predictor and comparator for the decoder
// Watches the configuration, packed byte and record channels, runs its own
// model of the decoder on every accepted byte and compares each accepted
// record, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlud_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [28:0] cfg_data_i,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  byte_data_i,   // [7:0] packed_byte
  input  logic        byte_last_i,
  input  logic        rec_valid_i,
  input  logic        rec_ready_i,
  input  logic [71:0] rec_data_i,    // [31:0] value, [39:32] run, [67:40] start, [71:68] pad
  input  logic [3:0]  rec_user_i,    // [0] unit_valid, [3:1] status
  output int          fail_count_o,
  output int          pending_o
);

  logic                        stride_q;
  logic [rlud_pkg::CountW-1:0] count_q;
  rlud_pkg::rlud_state_t       st;
  rlud_pkg::rlud_result_t      expected_q[$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: record %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    fail_count_o++;
  endtask

  // error exit: the rest of the stream is dropped unless this byte closed it
  function automatic void end_stream(input bit last);
    st = '0;
    st.discarding = !last;
  endfunction

  // one packed byte through the decoder; returns 1 when a record is due
  function automatic bit decode_step(input logic [7:0] b, input bit last,
                                     output rlud_pkg::rlud_result_t rec);
    int unsigned n;
    int unsigned run;
    int unsigned unit_size;
    logic [31:0] value;
    rec = '0;
    unit_size = stride_q ? 4 : 1;
    if (st.discarding) begin
      if (last) st = '0;
      return 1'b0;
    end
    if (64'(count_q) * 64'(unit_size) > 64'(rlud_pkg::MaxOutputBytes)) begin
      rec.status = rlud_pkg::StCountLarge;
      end_stream(last);
      return 1'b1;
    end
    if (st.phase == rlud_pkg::PhMarker) begin
      if (st.units_done >= count_q) begin
        rec.status = rlud_pkg::StMismatch;
        end_stream(last);
        return 1'b1;
      end
      n = b[7] ? b[6:0] + 3 : b + 1;
      if (n > count_q - st.units_done) begin
        rec.status = rlud_pkg::StRunOverflow;
        end_stream(last);
        return 1'b1;
      end
      if (last) begin
        rec.status = rlud_pkg::StTruncated;
        end_stream(last);
        return 1'b1;
      end
      st.units_left    = n[7:0];
      st.run_is_repeat = b[7];
      st.byte_in_unit  = '0;
      st.unit_bytes    = '0;
      st.phase         = rlud_pkg::PhUnit;
      return 1'b0;
    end
    if (st.byte_in_unit + 1 < unit_size) begin
      st.unit_bytes   = st.unit_bytes | (24'(b) << (8 * st.byte_in_unit));
      st.byte_in_unit = st.byte_in_unit + 2'd1;
      if (last) begin
        rec.status = rlud_pkg::StTruncated;
        end_stream(last);
        return 1'b1;
      end
      return 1'b0;
    end
    value = {8'h00, st.unit_bytes} | (32'(b) << (8 * st.byte_in_unit));
    run   = st.run_is_repeat ? st.units_left : 1;
    rec.unit_valid = 1'b1;
    rec.unit_value = value;
    rec.run_units  = run[7:0];
    rec.start_unit = st.units_done[rlud_pkg::StartW-1:0];
    st.units_done   = st.units_done + run[rlud_pkg::CountW-1:0];
    st.units_left   = st.run_is_repeat ? 8'd0 : st.units_left - 8'd1;
    st.byte_in_unit = '0;
    st.unit_bytes   = '0;
    if (st.units_left == 0) st.phase = rlud_pkg::PhMarker;
    if (last) begin
      if (st.units_left != 0)
        rec.status = rlud_pkg::StTruncated;
      else if (st.units_done == count_q)
        rec.status = rlud_pkg::StDoneOk;
      else
        rec.status = rlud_pkg::StMismatch;
      st = '0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rlud_pkg::rlud_result_t want;
    rlud_pkg::rlud_result_t rec;
    if (!rst_ni) begin
      stride_q = 1'b0;
      count_q  = '0;
      st       = '0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (rec_valid_i && rec_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("(none expected)", {28'd0, rec_user_i}, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (rec_user_i[0] !== want.unit_valid)
            report_mismatch("unit_valid", 32'(rec_user_i[0]), 32'(want.unit_valid));
          if (rec_data_i[31:0] !== want.unit_value)
            report_mismatch("unit_value", rec_data_i[31:0], want.unit_value);
          if (rec_data_i[39:32] !== want.run_units)
            report_mismatch("run_units", 32'(rec_data_i[39:32]), 32'(want.run_units));
          if (rec_data_i[67:40] !== want.start_unit)
            report_mismatch("start_unit", 32'(rec_data_i[67:40]), 32'(want.start_unit));
          if (rec_user_i[3:1] !== want.status)
            report_mismatch("status", 32'(rec_user_i[3:1]), 32'(want.status));
          if (rec_data_i[71:68] !== 4'd0)
            report_mismatch("pad", 32'(rec_data_i[71:68]), 32'd0);
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        if (decode_step(byte_data_i, byte_last_i, rec))
          expected_q.insert(expected_q.size(), rec);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == rlud_pkg::CfgStrideMode)
          stride_q = cfg_data_i[0];
        else
          count_q = cfg_data_i;
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: test/tb_run_length_unit_decoder.sv
// ----------------------------------------------------------------------------
// tb_run_length_unit_decoder: stream test of the run-length unit decoder
// Sends a short directed set of streams covering every error status and both
// unit sizes, then random well-formed and damaged streams under several
// register settings, with random gaps on both sides. Records are checked by
// rlud_record_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_run_length_unit_decoder;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [28:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tlast_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [71:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  int          failures;
  int          pending;
  int          bytes_sent;
  logic        idle_on;
  logic [7:0]  byte_q[$];
  bit          last_q[$];

  logic [28:0] edge_counts[6] = '{29'd0, 29'h400_0000, 29'h400_0001,
                                  29'h1000_0000, 29'h1000_0001, 29'h1FFF_FFFF};

  always #10 clk_i = ~clk_i;

  run_length_unit_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  rlud_record_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .byte_valid_i (s_axis_tvalid_i),
    .byte_ready_i (s_axis_tready_o),
    .byte_data_i  (s_axis_tdata_i),
    .byte_last_i  (s_axis_tlast_i),
    .rec_valid_i  (m_axis_tvalid_o),
    .rec_ready_i  (m_axis_tready_i),
    .rec_data_i   (m_axis_tdata_o),
    .rec_user_i   (m_axis_tuser_o),
    .fail_count_o (failures),
    .pending_o    (pending)
  );

  // record side back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
  end

  function automatic void queue_byte(input logic [7:0] b, input bit last);
    byte_q.insert(byte_q.size(), b);
    last_q.insert(last_q.size(), last);
  endfunction

  task automatic write_reg(input logic idx, input logic [28:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // streams chain without a gap; settle() drops tvalid afterwards
  task automatic send_stream();
    while (byte_q.size() > 0) begin
      while (idle_on && $urandom_range(99) < 23) begin
        s_axis_tvalid_i <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= byte_q.pop_front();
      s_axis_tlast_i  <= last_q.pop_front();
      do @(posedge clk_i); while (!s_axis_tready_o);
      bytes_sent++;
    end
  endtask

  // hold off until all records are in, then let the pipeline drain
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned units;
    int unsigned left;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic        wide;
    logic [28:0] count;
    rst_ni          <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= rlud_pkg::CfgStrideMode;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    idle_on         <= 1'b1;
    bytes_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count 0 after reset: any marker is surplus, rest is dropped
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    send_stream();
    settle();
    // oversize count, one-byte units
    write_reg(rlud_pkg::CfgUnitCount, 29'h1FFF_FFFF);
    queue_byte(8'h55, 1'b1);
    send_stream();
    settle();
    // just over the limit with four-byte units
    write_reg(rlud_pkg::CfgStrideMode, 29'd1);
    write_reg(rlud_pkg::CfgUnitCount, 29'h400_0001);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAA, 1'b1);
    send_stream();
    settle();
    // at the limit: longest repeat, then a 128-unit literal cut mid-unit
    write_reg(rlud_pkg::CfgUnitCount, 29'h400_0000);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b1);
    send_stream();
    settle();
    // clean stream, overflow, truncated marker, short stream
    write_reg(rlud_pkg::CfgStrideMode, 29'd0);
    write_reg(rlud_pkg::CfgUnitCount, 29'd4);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h84, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h11, 1'b0);
    queue_byte(8'h01, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h22, 1'b1);
    send_stream();
    settle();

    while (bytes_sent < 1150) begin
      idle_on <= !(bytes_sent >= 450 && bytes_sent < 700);
      wide = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 8)
        count = edge_counts[$urandom_range(5)];
      else if (pick < 12)
        count = 29'($urandom_range(29'h1FFF_FFFF));
      else if (pick < 25)
        count = wide ? 29'($urandom_range(100, 25)) : 29'($urandom_range(260, 40));
      else
        count = wide ? 29'($urandom_range(20)) : 29'($urandom_range(48));
      write_reg(rlud_pkg::CfgStrideMode, 29'(wide));
      write_reg(rlud_pkg::CfgUnitCount, count);
      repeat ($urandom_range(4, 1)) begin
        units = (count <= 300) ? count : $urandom_range(60, 1);
        left  = units;
        while (left > 0) begin
          if (left >= 3 && $urandom_range(1)) begin
            n = $urandom_range((left > 130) ? 130 : left, 3);
            queue_byte(8'h80 | 8'(n - 3), 1'b0);
            repeat (wide ? 4 : 1) queue_byte(8'($urandom), 1'b0);
          end else begin
            n = $urandom_range((left > 128) ? 128 : left, 1);
            queue_byte(8'(n - 1), 1'b0);
            repeat (n * (wide ? 4 : 1)) queue_byte(8'($urandom), 1'b0);
          end
          left -= n;
        end
        pick = $urandom_range(99);
        if (byte_q.size() == 0 || pick >= 92) begin
          // pure noise
          byte_q.delete();
          last_q.delete();
          repeat ($urandom_range(8, 1)) queue_byte(8'($urandom), $urandom_range(3) == 0);
        end else if (pick >= 85) begin
          k = $urandom_range(byte_q.size() - 1);
          byte_q[k] = byte_q[k] ^ 8'($urandom_range(255, 1));
        end else if (pick >= 70) begin
          k = $urandom_range(byte_q.size() - 1);
          while (byte_q.size() > k + 1) begin
            void'(byte_q.pop_back());
            void'(last_q.pop_back());
          end
        end else if (pick >= 60) begin
          // trailing bytes past the expected count
          repeat ($urandom_range(4, 1)) queue_byte(8'($urandom), 1'b0);
        end
        last_q[last_q.size() - 1] = 1'b1;
        send_stream();
      end
      settle();
    end

    settle();
    if (failures == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
src/rlud_pkg.sv
src/rlud_step.sv
src/run_length_unit_decoder.sv
test/rlud_record_checker.sv
test/tb_run_length_unit_decoder.sv
